/* rtl/core/slo_queue_scheduler_unit_macros.svh */
// assertion helpers for the scheduler
`ifndef SLO_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define SLO_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define SQS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define SQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* rtl/core/sqs_pkg.sv */
`default_nettype none
package sqs_pkg;
  localparam int unsigned TickW = 20;
  localparam logic [TickW-1:0] TickReset = 20'd1000;
  localparam int unsigned TimeW = 48;
  localparam int unsigned VrW = 64;
  localparam int unsigned DlW = 32;
  localparam int unsigned PrioW = 8;
  localparam int unsigned UtilW = 8;
  localparam int unsigned UtilDefault = 100;
  localparam int unsigned ScaleMul = UtilDefault * 256;

  typedef enum logic [2:0] {
    OP_SET_PRIO = 3'd0,
    OP_SET_DEADLINE = 3'd1,
    OP_SET_UTIL = 3'd2,
    OP_STATUS = 3'd3,
    OP_SCHEDULE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RESUME = 2'd1,
    ACT_SUSPEND = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHARGE,
    ST_PICK,
    ST_EMIT,
    ST_DONE
  } state_t;

  // per-queue record handed along the ring
  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic has_dl;
    logic signed [DlW-1:0] deadline;
    logic [UtilW-1:0] util;
    logic [VrW-1:0] vrt;
    logic running;
    logic [TimeW-1:0] last_resume;
    logic rdy;
    logic susp;
    logic [1:0] dev;
    logic [TimeW-1:0] rdy_since;
  } qrec_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic shift;
    logic [1:0] mode;
  } cell_ctl_t;

  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_CHARGE = 2'd1;
  localparam logic [1:0] MODE_EMIT = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/sqs_cell.sv */
`default_nettype none
module sqs_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sqs_pkg::cell_ctl_t ctl,
  input  wire logic load,
  input  wire sqs_pkg::qrec_t load_rec,
  input  wire sqs_pkg::qrec_t prev_rec,
  input  wire logic [47:0] now,
  input  wire logic chosen_in,
  input  wire sqs_pkg::qrec_t reset_rec,
  output sqs_pkg::qrec_t rec
);
  import sqs_pkg::*;
  qrec_t upd;
  qrec_t rec_next;

  // emit update only where the head record re-enters the ring
  always_comb begin
    upd = prev_rec;
    if (ctl.mode == MODE_EMIT) begin
      if (!prev_rec.rdy) begin
        upd.running = 1'b0;
      end else if (chosen_in) begin
        upd.running = 1'b1;
        upd.last_resume = now;
      end else begin
        upd.running = 1'b0;
      end
    end
  end

  always_comb begin
    rec_next = rec;
    if (load) begin
      rec_next = load_rec;
    end else if (ctl.shift) begin
      rec_next = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= reset_rec;
    end else begin
      rec <= rec_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sqs_div.sv */
`default_nettype none
module sqs_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [63:0] dividend,
  input  wire logic [7:0] divisor,
  output logic busy,
  output logic [63:0] quotient
);
  import sqs_pkg::*;
  logic [6:0] cnt;
  logic [7:0] rem;
  logic [8:0] trial;
  logic [63:0] q;

  assign trial = {rem, q[63]} - {1'b0, divisor};
  assign quotient = q;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      q <= dividend;
    end else if (busy) begin
      if (!trial[8]) begin
        rem <= trial[7:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[6:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/slo_queue_scheduler_unit.sv */
`default_nettype none
// slo queue scheduler
// input channel: valid/ready with operation, queue, amount, clear_deadline,
// ready_req, suspended, device, ready_since and now per request
// output channel: valid/ready, one request per queue (queue_out, action,
// chosen, last) for each schedule request, in queue index order
// cfg channel: cfg_valid/cfg_ready/cfg_data writes tick_us, taken only when idle
// hint and status requests give no output
// a schedule request first rotates the ring of queue cells once for the
// charge, each queue waiting on the serial divider, then walks the table
// by index once per device, then rotates the ring again to emit one
// request per cycle while the receiver takes them
// input ready returns after the last output is taken, once the sequencer
// passes through its done state back to idle
// reset returns every queue to defaults and tick_us to 1000
// a stalled receiver holds the ring and the output register; nothing is lost
// one request is in flight at a time
module slo_queue_scheduler_unit #(
  parameter int NUM_QUEUES = 16,
  parameter int NUM_DEVICES = 4,
  parameter int UTIL_MIN = 1,
  parameter int UTIL_MAX = 100,
  parameter int PRIO_MIN = -64,
  parameter int PRIO_MAX = 63
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] operation,
  input  wire logic [3:0] queue,
  input  wire logic signed [31:0] amount,
  input  wire logic clear_deadline,
  input  wire logic ready_req,
  input  wire logic suspended,
  input  wire logic [1:0] device,
  input  wire logic [47:0] ready_since,
  input  wire logic [47:0] now,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [19:0] cfg_data,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [3:0] queue_out,
  output logic [1:0] action,
  output logic chosen,
  output logic last
);
  import sqs_pkg::*;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = $clog2(NUM_QUEUES + 1);

  logic [TickW-1:0] tick_us;
  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] dev_cnt;
  logic [47:0] now_r;
  logic [2:0] op_r;
  logic [QW-1:0] q_r;
  logic q_ok_r;
  logic signed [31:0] amt_r;
  logic nd_r, rr_r, su_r;
  logic [1:0] dv_r;
  logic [47:0] rt_r;
  logic hint_pend;

  qrec_t recs [NUM_QUEUES];
  qrec_t head_new;
  cell_ctl_t ctl;
  cell_ctl_t ctl_fwd;
  logic chosen_head;
  logic [NUM_QUEUES-1:0] pick_mask;
  qrec_t reset_rec;
  logic load_any;
  logic [NUM_QUEUES-1:0] load_vec;
  qrec_t load_rec;

  // charge sub-phase
  logic div_start, div_busy, div_wait;
  logic [63:0] div_q;
  logic [63:0] charge_num;
  logic charge_go;
  logic [TimeW-1:0] ch_elapsed;
  logic [VrW:0] ch_sum;

  // pick walk: three candidates for the current device
  logic [QW-1:0] urg, lat, bat;
  logic urg_v, lat_v, bat_v;
  logic signed [49:0] urg_sl, lat_sl;
  logic signed [PrioW-1:0] urg_pr, lat_pr;
  logic lat_hd;
  logic [VrW-1:0] bat_vr;
  logic [QW-1:0] walk_idx;

  // output register
  logic [1:0] act_c;

  assign reset_rec = '{prio: '0, has_dl: 1'b0, deadline: '0,
    util: UtilW'(UtilDefault), vrt: '0, running: 1'b0, last_resume: '0,
    rdy: 1'b0, susp: 1'b0, dev: '0, rdy_since: '0};

  assign cfg_ready = (state == ST_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us <= TickReset;
    end else if (cfg_valid && cfg_ready) begin
      tick_us <= cfg_data;
    end
  end

  assign in_ready = (state == ST_IDLE) && !hint_pend;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= operation;
      q_r <= QW'(queue);
      q_ok_r <= ({28'b0, queue} < 32'(NUM_QUEUES));
      amt_r <= amount;
      nd_r <= clear_deadline;
      rr_r <= ready_req;
      su_r <= suspended;
      dv_r <= device;
      rt_r <= ready_since;
      now_r <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint_pend <= 1'b0;
    end else begin
      hint_pend <= in_valid && in_ready && (operation != OP_SCHEDULE);
    end
  end

  // hint write targets the cell directly
  always_comb begin
    logic signed [31:0] pc, uc;
    pc = amt_r;
    if (amt_r < 32'(PRIO_MIN)) pc = 32'(PRIO_MIN);
    if (amt_r > 32'(PRIO_MAX)) pc = 32'(PRIO_MAX);
    uc = amt_r;
    if (amt_r < 32'(UTIL_MIN)) uc = 32'(UTIL_MIN);
    if (amt_r > 32'(UTIL_MAX)) uc = 32'(UTIL_MAX);
    load_rec = recs[q_r];
    case (op_r)
      OP_SET_PRIO: load_rec.prio = pc[PrioW-1:0];
      OP_SET_DEADLINE: begin
        load_rec.has_dl = !nd_r;
        load_rec.deadline = nd_r ? '0 : amt_r;
      end
      OP_SET_UTIL: load_rec.util = uc[UtilW-1:0];
      OP_STATUS: begin
        load_rec.rdy = rr_r;
        load_rec.susp = su_r;
        load_rec.dev = dv_r;
        load_rec.rdy_since = rt_r;
      end
      default: ;
    endcase
    // out-of-range queue index: hint ignored
    load_any = hint_pend && (op_r <= OP_STATUS) && q_ok_r;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      load_vec[i] = load_any && (q_r == QW'(i));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && in_ready && operation == OP_SCHEDULE) state_next = ST_CHARGE;
      ST_CHARGE: if (charge_go && cnt == CW'(NUM_QUEUES - 1)) state_next = ST_PICK;
      ST_PICK: if (walk_idx == QW'(NUM_QUEUES - 1) &&
        dev_cnt == CW'(NUM_DEVICES - 1)) state_next = ST_EMIT;
      ST_EMIT: if ((!out_valid || out_ready) && cnt == CW'(NUM_QUEUES)) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // charge: head cell is processed, then ring rotates
  assign ch_elapsed = now_r - recs[0].last_resume;
  assign charge_num = 64'(ch_elapsed) * 64'(ScaleMul);
  assign ch_sum = {1'b0, recs[0].vrt} + {1'b0, div_q};
  assign charge_go = (state == ST_CHARGE) && div_wait && !div_busy && !div_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_wait <= 1'b0;
    end else if (state == ST_CHARGE && !div_wait) begin
      div_wait <= 1'b1;
    end else if (charge_go) begin
      div_wait <= 1'b0;
    end
  end
  assign div_start = (state == ST_CHARGE) && !div_wait;

  sqs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(charge_num),
    .divisor((recs[0].util == '0) ? 8'd1 : recs[0].util),
    .busy(div_busy), .quotient(div_q)
  );

  always_comb begin
    head_new = recs[0];
    if (state == ST_CHARGE && recs[0].running && now_r > recs[0].last_resume) begin
      head_new.vrt = ch_sum[VrW] ? '1 : ch_sum[VrW-1:0];
      head_new.last_resume = now_r;
    end
  end

  // pick walk over the table by index
  assign walk_idx = QW'(cnt);
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      dev_cnt <= '0;
      pick_mask <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          dev_cnt <= '0;
          pick_mask <= '0;
          urg_v <= 1'b0; lat_v <= 1'b0; bat_v <= 1'b0;
        end
        ST_CHARGE: if (charge_go) cnt <= (cnt == CW'(NUM_QUEUES - 1)) ? '0 : cnt + 1'b1;
        ST_PICK: begin
          qrec_t r;
          logic signed [49:0] s;
          logic isu, better_u, better_l;
          r = recs[walk_idx];
          s = $signed({{18{r.deadline[31]}}, r.deadline}) -
            ($signed({2'b0, now_r}) - $signed({2'b0, r.rdy_since}));
          isu = r.has_dl && (s <= $signed({30'b0, tick_us}));
          better_u = !urg_v || s < urg_sl || (s == urg_sl && r.prio > urg_pr);
          better_l = !lat_v || r.prio > lat_pr ||
            (r.prio == lat_pr && r.has_dl && (!lat_hd || s < lat_sl));
          if (r.rdy && 32'(r.dev) == 32'(dev_cnt)) begin
            if (isu && better_u) begin
              urg <= walk_idx; urg_v <= 1'b1; urg_sl <= s; urg_pr <= r.prio;
            end
            if (r.has_dl || r.prio > 0) begin
              if (better_l) begin
                lat <= walk_idx; lat_v <= 1'b1; lat_sl <= s; lat_pr <= r.prio;
                lat_hd <= r.has_dl;
              end
            end else if (!bat_v || r.vrt < bat_vr) begin
              bat <= walk_idx; bat_v <= 1'b1; bat_vr <= r.vrt;
            end
          end
          if (walk_idx == QW'(NUM_QUEUES - 1)) begin
            if (urg_v || (r.rdy && 32'(r.dev) == 32'(dev_cnt) && isu && better_u))
              pick_mask[(r.rdy && 32'(r.dev) == 32'(dev_cnt) && isu && better_u) ?
                walk_idx : urg] <= 1'b1;
            else if (lat_v || (r.rdy && 32'(r.dev) == 32'(dev_cnt) &&
              (r.has_dl || r.prio > 0)))
              pick_mask[(r.rdy && 32'(r.dev) == 32'(dev_cnt) &&
                (r.has_dl || r.prio > 0) && better_l) ? walk_idx : lat] <= 1'b1;
            else if (bat_v || (r.rdy && 32'(r.dev) == 32'(dev_cnt)))
              pick_mask[(r.rdy && 32'(r.dev) == 32'(dev_cnt) &&
                (!bat_v || r.vrt < bat_vr)) ? walk_idx : bat] <= 1'b1;
            urg_v <= 1'b0; lat_v <= 1'b0; bat_v <= 1'b0;
            cnt <= '0;
            dev_cnt <= dev_cnt + 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EMIT: if (!out_valid || out_ready) begin
          cnt <= cnt + 1'b1;
          pick_mask <= pick_mask >> 1;
        end
        default: ;
      endcase
    end
  end

  // ring control; only the cell fed from the head applies the emit update
  always_comb begin
    ctl.shift = charge_go || ((state == ST_EMIT) && (!out_valid || out_ready) &&
      cnt != CW'(NUM_QUEUES));
    ctl.mode = (state == ST_EMIT) ? MODE_EMIT : MODE_CHARGE;
    ctl_fwd.shift = ctl.shift;
    ctl_fwd.mode = MODE_HOLD;
    // a picked queue is always ready and on a device in range
    chosen_head = pick_mask[0];
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_cell
    sqs_cell u_cell (
      .clk(clk), .rst(rst), .ctl((g == NUM_QUEUES - 1) ? ctl : ctl_fwd),
      .load(load_vec[g]), .load_rec(load_rec),
      .prev_rec((g == NUM_QUEUES - 1) ? head_new : recs[(g + 1) % NUM_QUEUES]),
      .now(now_r), .chosen_in(chosen_head && (g == NUM_QUEUES - 1)),
      .reset_rec(reset_rec), .rec(recs[g])
    );
  end

  // output register
  always_comb begin
    act_c = ACT_NONE;
    if (recs[0].rdy) begin
      if (chosen_head) act_c = recs[0].running ? ACT_NONE : ACT_RESUME;
      else if (recs[0].running || !recs[0].susp) act_c = ACT_SUSPEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= (state == ST_EMIT) && cnt != CW'(NUM_QUEUES);
      queue_out <= 4'(cnt);
      action <= act_c;
      chosen <= chosen_head;
      last <= (cnt == CW'(NUM_QUEUES - 1));
    end
  end

  `include "slo_queue_scheduler_unit_macros.svh"
  `SQS_ASSERT_IMPL(a_idle_no_out, state == ST_IDLE, !out_valid)
  `SQS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SQS_ASSERT_IMPL(a_no_in_busy, state != ST_IDLE, !in_ready)
endmodule
`default_nettype wire
